[rtl/ssm_pkg.sv]
// package for the sorted sequence merge unit
// holds default sizes, command codes, sequencer states and helpers
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ssm_pkg;

    // default sizes for the top level parameters
    localparam int DEF_SEQUENCE_DEPTH = 32;
    localparam int DEF_VALUE_BITS     = 32;

    // fixed widths of the channel payload
    localparam int CMD_W   = 2;
    localparam int FIELD_W = 32;

    // command codes
    localparam logic [CMD_W-1:0] CMD_APPEND_FIRST  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND_SECOND = 2'd1;
    localparam logic [CMD_W-1:0] CMD_MERGE         = 2'd2;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_PICK,
        ST_SEND
    } state_t;

    // address bits for a store of the given depth, at least one
    function automatic int addr_bits(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

    // counter bits that can hold the depth itself
    function automatic int count_bits(input int depth);
        return $clog2(depth + 1);
    endfunction

endpackage

`default_nettype wire

[rtl/ssm_if.sv]
// valid/ready channel interfaces for the merge unit
// depends on ssm_pkg for payload widths
`timescale 1ns / 1ps
`default_nettype none

interface ssm_in_if
    import ssm_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [CMD_W-1:0]          command;
    logic signed [FIELD_W-1:0] value;

    modport source (output valid, output command, output value, input ready);
    modport sink   (input valid, input command, input value, output ready);
endinterface

interface ssm_out_if
    import ssm_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [FIELD_W-1:0] merged_value;
    logic                      from_second;
    logic                      last_value;
    logic                      both_empty;
    logic                      overflowed;

    modport source (output valid, output merged_value, output from_second,
                    output last_value, output both_empty, output overflowed,
                    input ready);
    modport sink   (input valid, input merged_value, input from_second,
                    input last_value, input both_empty, input overflowed,
                    output ready);
endinterface

`default_nettype wire

[rtl/ssm_ram.sv]
// generic single write port ram with registered read
// depends on ssm_pkg for address width helper
`timescale 1ns / 1ps
`default_nettype none

module ssm_ram
    import ssm_pkg::*;
#(
    parameter int WIDTH = DEF_VALUE_BITS,
    parameter int DEPTH = DEF_SEQUENCE_DEPTH
) (
    input  wire logic                          clk,
    input  wire logic                          wr_en,
    input  wire logic [addr_bits(DEPTH)-1:0]   wr_addr,
    input  wire logic [WIDTH-1:0]              wr_data,
    input  wire logic [addr_bits(DEPTH)-1:0]   rd_addr,
    output      logic [WIDTH-1:0]              rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

[rtl/ssm_seq.sv]
// merge sequencer: store counts, head indexes, shared signed compare, output register
// depends on ssm_pkg and ssm_if; drives the two store rams in the top level
`timescale 1ns / 1ps
`default_nettype none

module ssm_seq
    import ssm_pkg::*;
#(
    parameter int SEQUENCE_DEPTH = DEF_SEQUENCE_DEPTH,
    parameter int VALUE_BITS     = DEF_VALUE_BITS
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    ssm_in_if.sink                                    in_ch,
    ssm_out_if.source                                 out_ch,
    output      logic                                 wr_a,
    output      logic                                 wr_b,
    output      logic [addr_bits(SEQUENCE_DEPTH)-1:0] wr_addr_a,
    output      logic [addr_bits(SEQUENCE_DEPTH)-1:0] wr_addr_b,
    output      logic [VALUE_BITS-1:0]                wr_data,
    output      logic [addr_bits(SEQUENCE_DEPTH)-1:0] rd_addr_a,
    output      logic [addr_bits(SEQUENCE_DEPTH)-1:0] rd_addr_b,
    input  wire logic [VALUE_BITS-1:0]                rd_data_a,
    input  wire logic [VALUE_BITS-1:0]                rd_data_b
);

    localparam int AW = addr_bits(SEQUENCE_DEPTH);
    localparam int CW = count_bits(SEQUENCE_DEPTH);
    localparam logic [CW-1:0] FULL = CW'(SEQUENCE_DEPTH);

    state_t state_reg, state_next;

    logic [CW-1:0] cnt_a_reg, cnt_a_next;
    logic [CW-1:0] cnt_b_reg, cnt_b_next;
    logic [CW-1:0] idx_a_reg, idx_a_next;
    logic [CW-1:0] idx_b_reg, idx_b_next;
    logic          ovf_reg, ovf_next;

    logic [FIELD_W-1:0] val_reg, val_next;
    logic               sec_reg, sec_next;
    logic               last_reg, last_next;
    logic               empty_reg, empty_next;

    logic                  in_acc;
    logic                  out_acc;
    logic                  take_first;
    logic [VALUE_BITS-1:0] pick_val;
    logic [FIELD_W-1:0]    pick_ext;

    assign in_acc  = in_ch.valid && in_ch.ready;
    assign out_acc = out_ch.valid && out_ch.ready;

    // input value resized to store width, stored value resized to field width (truncate or sign extend)
    generate
        if (VALUE_BITS > FIELD_W)
        begin : g_wide
            assign wr_data  = {{(VALUE_BITS - FIELD_W){in_ch.value[FIELD_W-1]}},
                               in_ch.value};
            assign pick_ext = pick_val[FIELD_W-1:0];
        end
        else if (VALUE_BITS < FIELD_W)
        begin : g_narrow
            assign wr_data  = in_ch.value[VALUE_BITS-1:0];
            assign pick_ext = {{(FIELD_W - VALUE_BITS){pick_val[VALUE_BITS-1]}},
                               pick_val};
        end
        else
        begin : g_same
            assign wr_data  = in_ch.value;
            assign pick_ext = pick_val;
        end
    endgenerate

    // store ports
    assign wr_addr_a = cnt_a_reg[AW-1:0];
    assign wr_addr_b = cnt_b_reg[AW-1:0];
    assign rd_addr_a = idx_a_reg[AW-1:0];
    assign rd_addr_b = idx_b_reg[AW-1:0];

    // shared compare: first head wins only when strictly smaller
    always_comb
    begin
        if (idx_a_reg >= cnt_a_reg)
        begin
            take_first = 1'b0;
        end
        else if (idx_b_reg >= cnt_b_reg)
        begin
            take_first = 1'b1;
        end
        else
        begin
            take_first = $signed(rd_data_a) < $signed(rd_data_b);
        end
        pick_val = take_first ? rd_data_a : rd_data_b;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && in_ch.command == CMD_MERGE)
                begin
                    if (cnt_a_reg == '0 && cnt_b_reg == '0)
                    begin
                        state_next = ST_SEND;
                    end
                    else
                    begin
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_FETCH:
            begin
                state_next = ST_PICK;
            end
            ST_PICK:
            begin
                state_next = ST_SEND;
            end
            ST_SEND:
            begin
                if (out_acc)
                begin
                    state_next = last_reg ? ST_IDLE : ST_FETCH;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // handshake outputs
    always_comb
    begin
        in_ch.ready  = 1'b0;
        out_ch.valid = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ch.ready = 1'b1;
            end
            ST_SEND:
            begin
                out_ch.valid = 1'b1;
            end
            default:
            begin
                in_ch.ready  = 1'b0;
                out_ch.valid = 1'b0;
            end
        endcase
    end

    // datapath next values
    always_comb
    begin
        cnt_a_next = cnt_a_reg;
        cnt_b_next = cnt_b_reg;
        idx_a_next = idx_a_reg;
        idx_b_next = idx_b_reg;
        ovf_next   = ovf_reg;
        val_next   = val_reg;
        sec_next   = sec_reg;
        last_next  = last_reg;
        empty_next = empty_reg;
        wr_a       = 1'b0;
        wr_b       = 1'b0;

        // appends and merge start
        if (state_reg == ST_IDLE && in_acc)
        begin
            if (in_ch.command == CMD_APPEND_FIRST)
            begin
                if (cnt_a_reg < FULL)
                begin
                    wr_a       = 1'b1;
                    cnt_a_next = cnt_a_reg + CW'(1);
                end
                else
                begin
                    ovf_next = 1'b1;
                end
            end
            else if (in_ch.command == CMD_APPEND_SECOND)
            begin
                if (cnt_b_reg < FULL)
                begin
                    wr_b       = 1'b1;
                    cnt_b_next = cnt_b_reg + CW'(1);
                end
                else
                begin
                    ovf_next = 1'b1;
                end
            end
            else if (in_ch.command == CMD_MERGE)
            begin
                idx_a_next = '0;
                idx_b_next = '0;
                val_next   = '0;
                sec_next   = 1'b0;
                last_next  = 1'b1;
                empty_next = 1'b1;
            end
        end

        // one merge step: take a head, advance its index
        if (state_reg == ST_PICK)
        begin
            if (take_first)
            begin
                idx_a_next = idx_a_reg + CW'(1);
            end
            else
            begin
                idx_b_next = idx_b_reg + CW'(1);
            end
            val_next   = pick_ext;
            sec_next   = !take_first;
            last_next  = (idx_a_next == cnt_a_reg) && (idx_b_next == cnt_b_reg);
            empty_next = 1'b0;
        end

        // final item taken: empty both stores
        if (state_reg == ST_SEND && out_acc && last_reg)
        begin
            cnt_a_next = '0;
            cnt_b_next = '0;
            idx_a_next = '0;
            idx_b_next = '0;
            ovf_next   = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_a_reg <= '0;
            cnt_b_reg <= '0;
            idx_a_reg <= '0;
            idx_b_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_a_reg <= cnt_a_next;
            cnt_b_reg <= cnt_b_next;
            idx_a_reg <= idx_a_next;
            idx_b_reg <= idx_b_next;
            ovf_reg   <= ovf_next;
        end
    end

    // output payload registers
    always_ff @(posedge clk)
    begin
        val_reg   <= val_next;
        sec_reg   <= sec_next;
        last_reg  <= last_next;
        empty_reg <= empty_next;
    end

    assign out_ch.merged_value = val_reg;
    assign out_ch.from_second  = sec_reg;
    assign out_ch.last_value   = last_reg;
    assign out_ch.both_empty   = empty_reg;
    assign out_ch.overflowed   = ovf_reg;

endmodule

`default_nettype wire

[rtl/sorted_sequence_merge_unit.sv]
// top level of the sorted sequence merge unit: two store rams and the merge sequencer
// depends on ssm_pkg, ssm_if, ssm_ram and ssm_seq
//
//   channel   dir   payload                                            accepted when
//   in_ch     in    command[1:0], value[31:0]                          valid && ready
//   out_ch    out   merged_value[31:0], from_second, last_value,       valid && ready
//                   both_empty, overflowed
//
// an append leaves the input ready
// a merge emits one item at a time, the next fetched only after out_ch takes the last:
// head read from the store rams, compare and register, then send
// an empty merge emits its single item in the cycle after the command
// input is not ready from a merge command until its last item is taken
// reset clears counts, indexes, overflow flag and sequencer; the rams need no clearing
`timescale 1ns / 1ps
`default_nettype none

module sorted_sequence_merge_unit
    import ssm_pkg::*;
#(
    parameter int SEQUENCE_DEPTH = DEF_SEQUENCE_DEPTH,
    parameter int VALUE_BITS     = DEF_VALUE_BITS
) (
    input  wire logic clk,
    input  wire logic rst_n,
    ssm_in_if.sink    in_ch,
    ssm_out_if.source out_ch
);

    localparam int AW = addr_bits(SEQUENCE_DEPTH);

    logic                  wr_a;
    logic                  wr_b;
    logic [AW-1:0]         wr_addr_a;
    logic [AW-1:0]         wr_addr_b;
    logic [VALUE_BITS-1:0] wr_data;
    logic [AW-1:0]         rd_addr_a;
    logic [AW-1:0]         rd_addr_b;
    logic [VALUE_BITS-1:0] rd_data_a;
    logic [VALUE_BITS-1:0] rd_data_b;

    // first sequence store
    ssm_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (SEQUENCE_DEPTH)
    ) u_store_a (
        .clk     (clk),
        .wr_en   (wr_a),
        .wr_addr (wr_addr_a),
        .wr_data (wr_data),
        .rd_addr (rd_addr_a),
        .rd_data (rd_data_a)
    );

    // second sequence store
    ssm_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (SEQUENCE_DEPTH)
    ) u_store_b (
        .clk     (clk),
        .wr_en   (wr_b),
        .wr_addr (wr_addr_b),
        .wr_data (wr_data),
        .rd_addr (rd_addr_b),
        .rd_data (rd_data_b)
    );

    // merge sequencer
    ssm_seq #(
        .SEQUENCE_DEPTH (SEQUENCE_DEPTH),
        .VALUE_BITS     (VALUE_BITS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .wr_a      (wr_a),
        .wr_b      (wr_b),
        .wr_addr_a (wr_addr_a),
        .wr_addr_b (wr_addr_b),
        .wr_data   (wr_data),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

endmodule

`default_nettype wire
